[hdl/thick_line_rasterizer_unit_defines.svh]
// assertion macros for the thick line rasterizer checks
`ifndef THICK_LINE_RASTERIZER_UNIT_DEFINES_SVH
`define THICK_LINE_RASTERIZER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define TLR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tlr check failed");

// next-cycle implication, clocked on clk, off during reset
`define TLR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tlr check failed");

`endif

[hdl/tlr_pkg.sv]
// shared types and constants of the thick line rasterizer
package tlr_pkg;

	localparam int COORD_BITS = 12;
	localparam int DW         = COORD_BITS + 1;
	localparam int CW         = COORD_BITS + 2;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	localparam logic [0:0] REG_SCREEN_WIDTH  = 1'b0;
	localparam logic [0:0] REG_SCREEN_HEIGHT = 1'b1;

	localparam logic [7:0] SCREEN_WIDTH_RESET  = 8'd128;
	localparam logic [7:0] SCREEN_HEIGHT_RESET = 8'd128;

	typedef logic signed [CW-1:0] wide_t;

	typedef struct packed {
		logic                         mode;
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic [15:0]                  line_color;
		logic [7:0]                   brush_size;
	} item_t;

	typedef struct packed {
		logic [7:0]  pixel_x;
		logic [7:0]  pixel_y;
		logic [15:0] pixel_color;
		logic        write_enable;
		logic        last_cell;
	} pix_t;

	typedef struct packed {
		logic          is_start;
		logic          steep;
		logic          dir;
		logic [DW-1:0] major_delta;
		logic [DW-1:0] minor_delta;
		wide_t         d_init;
		wide_t         x_lo;
		wide_t         x_hi;
		wide_t         y_lo;
		wide_t         y_hi;
		logic [15:0]   color;
	} cmd_t;

endpackage

[hdl/thick_line_rasterizer_unit.sv]
// thick line rasterizer top level
//
//   port group  dir   handshake            payload
//   cfg_*       in    cfg_valid/cfg_ready  cfg_index, cfg_data
//   item_*      in    item_valid/item_stall item_data (tlr_pkg::item_t)
//   pix_*       out   pix_valid/pix_stall  pix_data (tlr_pkg::pix_t)
//
// one brush pixel per clock while ticks keep coming and pix_stall is low
// an item goes through stages s1, s2, s3 and the queue; the stepper registers pix_data
// the stepper emits a pixel and computes the next brush box in the same cycle
// reset clears the pipeline, the queue and the line state; screen size goes to 128 x 128
// item_stall rises only when the command queue is full and its tail stage is loaded
module thick_line_rasterizer_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [0:0]     cfg_index,
	input  logic [7:0]     cfg_data,
	input  logic           item_valid,
	output logic           item_stall,
	input  tlr_pkg::item_t item_data,
	output logic           pix_valid,
	input  logic           pix_stall,
	output tlr_pkg::pix_t  pix_data
);
	import tlr_pkg::*;

	logic [7:0] screen_width_q, screen_height_q;
	logic       cmd_valid, q_full, q_pop, head_valid;
	cmd_t       cmd, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RESET;
			screen_height_q <= SCREEN_HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default:           screen_width_q  <= screen_width_q;
			endcase
		end
	end

	tlr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_data  (item_data),
		.q_full     (q_full),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd)
	);

	tlr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_valid),
		.push_data  (cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	tlr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (q_pop),
		.pix_valid     (pix_valid),
		.pix_stall     (pix_stall),
		.pix_data      (pix_data)
	);

endmodule

[hdl/tlr_front.sv]
// front pipeline: accepts items and sets up line walks
module tlr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  tlr_pkg::item_t item_data,
	input  logic          q_full,
	output logic          cmd_valid,
	output tlr_pkg::cmd_t cmd
);
	import tlr_pkg::*;

	logic en;

	logic                         valid_s1;
	logic                         mode_s1;
	logic signed [COORD_BITS-1:0] x0_s1, y0_s1, x1_s1, y1_s1;
	logic signed [DW-1:0]         dx_s1, dy_s1;
	logic [15:0]                  color_s1;
	logic [7:0]                   brush_s1;

	logic                         valid_s2;
	logic                         mode_s2;
	logic                         steep_s2, dir_s2;
	logic [DW-1:0]                maj_s2, min_s2;
	logic signed [COORD_BITS-1:0] sx_s2, sy_s2;
	logic [6:0]                   half_s2;
	logic signed [8:0]            hoff_s2;
	logic [15:0]                  color_s2;

	logic  valid_s3;
	cmd_t  cmd_s3;

	logic [DW-1:0]        adx, ady;
	logic                 steep, order, dir;
	logic signed [DW-1:0] mn;

	wide_t sx_w, sy_w, half_w, hoff_w;

	assign en         = !(valid_s3 && q_full);
	assign item_stall = !en;
	assign cmd_valid  = valid_s3 && !q_full;
	assign cmd        = cmd_s3;

	always_comb begin
		adx   = dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
		ady   = dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);
		steep = ady > adx;
		order = steep ? dy_s1[DW-1] : dx_s1[DW-1];
		mn    = steep ? dx_s1 : dy_s1;
		dir   = order ? mn[DW-1] : (!mn[DW-1] && (mn != '0));
	end

	always_comb begin
		sx_w   = {{(CW-COORD_BITS){sx_s2[COORD_BITS-1]}}, sx_s2};
		sy_w   = {{(CW-COORD_BITS){sy_s2[COORD_BITS-1]}}, sy_s2};
		half_w = {{(CW-7){1'b0}}, half_s2};
		hoff_w = {{(CW-9){hoff_s2[8]}}, hoff_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= item_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: raw differences
			mode_s1  <= item_data.mode;
			x0_s1    <= item_data.start_x;
			y0_s1    <= item_data.start_y;
			x1_s1    <= item_data.end_x;
			y1_s1    <= item_data.end_y;
			dx_s1    <= {item_data.end_x[COORD_BITS-1], item_data.end_x}
				- {item_data.start_x[COORD_BITS-1], item_data.start_x};
			dy_s1    <= {item_data.end_y[COORD_BITS-1], item_data.end_y}
				- {item_data.start_y[COORD_BITS-1], item_data.start_y};
			color_s1 <= item_data.line_color;
			brush_s1 <= item_data.brush_size;

			// stage 2: octant, ordering, deltas
			mode_s2  <= mode_s1;
			steep_s2 <= steep;
			dir_s2   <= dir;
			maj_s2   <= steep ? ady : adx;
			min_s2   <= steep ? adx : ady;
			sx_s2    <= order ? x1_s1 : x0_s1;
			sy_s2    <= order ? y1_s1 : y0_s1;
			half_s2  <= brush_s1[7:1];
			hoff_s2  <= $signed({1'b0, brush_s1}) - 9'sd1 - $signed({2'b00, brush_s1[7:1]});
			color_s2 <= color_s1;

			// stage 3: brush corners and initial error
			cmd_s3.is_start    <= (mode_s2 == MODE_START);
			cmd_s3.steep       <= steep_s2;
			cmd_s3.dir         <= dir_s2;
			cmd_s3.major_delta <= maj_s2;
			cmd_s3.minor_delta <= min_s2;
			cmd_s3.d_init      <= {1'b0, maj_s2 >> 1} - {1'b0, min_s2};
			cmd_s3.x_lo        <= sx_w - half_w;
			cmd_s3.x_hi        <= sx_w + hoff_w;
			cmd_s3.y_lo        <= sy_w - half_w;
			cmd_s3.y_hi        <= sy_w + hoff_w;
			cmd_s3.color       <= color_s2;
		end
	end

endmodule

[hdl/tlr_queue.sv]
// command queue between front and back
module tlr_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tlr_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output tlr_pkg::cmd_t head
);
	import tlr_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          do_push, do_pop;

	assign full       = (count_q == NW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[hdl/tlr_back.sv]
// back end: steps the line and emits brush pixels
module tlr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    screen_width,
	input  logic [7:0]    screen_height,
	input  logic          head_valid,
	input  tlr_pkg::cmd_t head,
	output logic          pop,
	output logic          pix_valid,
	input  logic          pix_stall,
	output tlr_pkg::pix_t pix_data
);
	import tlr_pkg::*;

	typedef struct packed {
		logic       empty;
		logic [7:0] xl;
		logic [7:0] xh;
		logic [7:0] yl;
		logic [7:0] yh;
	} box_t;

	function automatic box_t clip(input wide_t xl, input wide_t xh, input wide_t yl,
			input wide_t yh, input logic [7:0] sw, input logic [7:0] sh);
		wide_t lim_x, lim_y, cxl, cxh, cyl, cyh;
		box_t  b;
		lim_x   = {{(CW-8){1'b0}}, sw} - wide_t'(1);
		lim_y   = {{(CW-8){1'b0}}, sh} - wide_t'(1);
		cxl     = xl[CW-1] ? '0 : xl;
		cyl     = yl[CW-1] ? '0 : yl;
		cxh     = (xh > lim_x) ? lim_x : xh;
		cyh     = (yh > lim_y) ? lim_y : yh;
		b.empty = (cxl > cxh) || (cyl > cyh);
		b.xl    = cxl[7:0];
		b.xh    = cxh[7:0];
		b.yl    = cyl[7:0];
		b.yh    = cyh[7:0];
		return b;
	endfunction

	logic          busy_q, steep_q, dir_q;
	logic [DW-1:0] maj_q, min_q, remain_q;
	wide_t         d_q, xl_q, xh_q, yl_q, yh_q;
	logic [15:0]   color_q;
	box_t          box_q;
	logic [7:0]    col_q, row_q;
	logic          pix_valid_q;
	pix_t          pix_q;

	logic  out_free, do_tick, row_wrap, col_end, step_done, last;
	wide_t inc_minor, nxl, nxh, nyl, nyh, d_next;
	box_t  start_box, next_box;

	assign out_free  = !pix_valid_q || !pix_stall;
	assign pop       = head_valid && (head.is_start || !busy_q || out_free);
	assign do_tick   = head_valid && !head.is_start && busy_q && out_free;
	assign pix_valid = pix_valid_q;
	assign pix_data  = pix_q;

	always_comb begin
		row_wrap  = row_q >= box_q.yh;
		col_end   = col_q >= box_q.xh;
		step_done = box_q.empty || (row_wrap && col_end);
		last      = step_done && (remain_q == '0);

		inc_minor = d_q[CW-1] ? (dir_q ? wide_t'(1) : wide_t'(-1)) : '0;
		d_next    = d_q[CW-1] ? d_q - {1'b0, min_q} + {1'b0, maj_q} : d_q - {1'b0, min_q};
		if (steep_q) begin
			nxl = xl_q + inc_minor;
			nxh = xh_q + inc_minor;
			nyl = yl_q + wide_t'(1);
			nyh = yh_q + wide_t'(1);
		end else begin
			nxl = xl_q + wide_t'(1);
			nxh = xh_q + wide_t'(1);
			nyl = yl_q + inc_minor;
			nyh = yh_q + inc_minor;
		end
		next_box  = clip(nxl, nxh, nyl, nyh, screen_width, screen_height);
		start_box = clip(head.x_lo, head.x_hi, head.y_lo, head.y_hi,
			screen_width, screen_height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pix_valid_q <= 1'b0;
		end else begin
			if (pop && head.is_start) begin
				busy_q <= 1'b1;
			end else if (do_tick && last) begin
				busy_q <= 1'b0;
			end
			if (do_tick) begin
				pix_valid_q <= 1'b1;
			end else if (!pix_stall) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.is_start) begin
			steep_q  <= head.steep;
			dir_q    <= head.dir;
			maj_q    <= head.major_delta;
			min_q    <= head.minor_delta;
			remain_q <= head.major_delta;
			d_q      <= head.d_init;
			xl_q     <= head.x_lo;
			xh_q     <= head.x_hi;
			yl_q     <= head.y_lo;
			yh_q     <= head.y_hi;
			color_q  <= head.color;
			box_q    <= start_box;
			col_q    <= start_box.xl;
			row_q    <= start_box.yl;
		end else if (do_tick) begin
			pix_q.pixel_x      <= box_q.empty ? 8'd0 : col_q;
			pix_q.pixel_y      <= box_q.empty ? 8'd0 : row_q;
			pix_q.pixel_color  <= color_q;
			pix_q.write_enable <= !box_q.empty;
			pix_q.last_cell    <= last;
			if (step_done) begin
				if (!last) begin
					remain_q <= remain_q - 1'b1;
					d_q      <= d_next;
					xl_q     <= nxl;
					xh_q     <= nxh;
					yl_q     <= nyl;
					yh_q     <= nyh;
					box_q    <= next_box;
					col_q    <= next_box.xl;
					row_q    <= next_box.yl;
				end
			end else if (!row_wrap) begin
				row_q <= row_q + 1'b1;
			end else begin
				row_q <= box_q.yl;
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

[hdl/tlr_checker.sv]
// port checks for the thick line rasterizer
`include "thick_line_rasterizer_unit_defines.svh"

module tlr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          pix_valid,
	input logic          pix_stall,
	input tlr_pkg::pix_t pix_data
);
	import tlr_pkg::*;

	// a stalled pixel transfer holds
	`TLR_ASSERT_NEXT(a_pix_hold, pix_valid && pix_stall, pix_valid && $stable(pix_data))

	// a clipped step carries the origin
	`TLR_ASSERT_NOW(a_clip_zero, pix_valid && !pix_data.write_enable, pix_data.pixel_x == 8'd0 && pix_data.pixel_y == 8'd0)

	// written pixels stay inside the largest screen
	`TLR_ASSERT_NOW(a_in_range, pix_valid && pix_data.write_enable, pix_data.pixel_x != 8'd255 && pix_data.pixel_y != 8'd255)

endmodule

bind thick_line_rasterizer_unit tlr_checker u_tlr_checker (.*);

[sim/tb_thick_line_rasterizer_unit.sv]
// self-checking testbench for the thick line rasterizer: predicts brush cells and compares them
module tb_thick_line_rasterizer_unit;
	import tlr_pkg::*;

	class line_cell_checker;
		int          scr_w = SCREEN_WIDTH_RESET;
		int          scr_h = SCREEN_HEIGHT_RESET;
		bit          busy;
		bit          steep;
		bit          dir;
		int          major_pos;
		int          major_end;
		int          minor_pos;
		int          major_delta;
		int          minor_delta;
		int          err_acc;
		logic [15:0] color;
		int          brush;
		int          col;
		int          row;
		int          x_lo;
		int          x_hi;
		int          y_lo;
		int          y_hi;
		bit          box_empty;
		int          faults;
		pix_t        cells_due[$];

		function int mag(int v);
			return (v < 0) ? -v : v;
		endfunction

		function void set_reg(logic [0:0] idx, logic [7:0] val);
			if (idx == REG_SCREEN_WIDTH) begin
				scr_w = val;
			end else begin
				scr_h = val;
			end
		endfunction

		function bit line_open();
			return busy;
		endfunction

		function bit waiting();
			return cells_due.size() != 0;
		endfunction

		// clipped brush box of the current step
		function void place_brush();
			int px;
			int py;
			int xl;
			int yl;
			int xh;
			int yh;
			px = steep ? minor_pos : major_pos;
			py = steep ? major_pos : minor_pos;
			xl = px - brush / 2;
			yl = py - brush / 2;
			xh = xl + brush - 1;
			yh = yl + brush - 1;
			if (xl < 0) xl = 0;
			if (yl < 0) yl = 0;
			if (xh > scr_w - 1) xh = scr_w - 1;
			if (yh > scr_h - 1) yh = scr_h - 1;
			if (brush == 0 || xl > xh || yl > yh) begin
				box_empty = 1'b1;
				col = 0;
				row = 0;
			end else begin
				box_empty = 1'b0;
				x_lo = xl;
				x_hi = xh;
				y_lo = yl;
				y_hi = yh;
				col = xl;
				row = yl;
			end
		endfunction

		// notes an accepted input transfer, returns 1 if it starts or advances a line
		function bit take_item(item_t it);
			int   x0;
			int   y0;
			int   x1;
			int   y1;
			int   t;
			bit   step_done;
			pix_t p;
			if (it.mode == MODE_START) begin
				x0 = $signed(it.start_x);
				y0 = $signed(it.start_y);
				x1 = $signed(it.end_x);
				y1 = $signed(it.end_y);
				steep = mag(y1 - y0) > mag(x1 - x0);
				if (steep) begin
					t = x0; x0 = y0; y0 = t;
					t = x1; x1 = y1; y1 = t;
				end
				if (x0 > x1) begin
					t = x0; x0 = x1; x1 = t;
					t = y0; y0 = y1; y1 = t;
				end
				major_pos = x0;
				major_end = x1;
				minor_pos = y0;
				major_delta = x1 - x0;
				minor_delta = mag(y1 - y0);
				err_acc = major_delta / 2;
				dir = y0 < y1;
				color = it.line_color;
				brush = it.brush_size;
				busy = 1'b1;
				place_brush();
				return 1'b1;
			end
			if (!busy) return 1'b0;
			p.pixel_x = box_empty ? 8'd0 : col[7:0];
			p.pixel_y = box_empty ? 8'd0 : row[7:0];
			p.pixel_color = color;
			p.write_enable = !box_empty;
			p.last_cell = 1'b0;
			step_done = 1'b0;
			if (box_empty) begin
				step_done = 1'b1;
			end else if (row < y_hi) begin
				row++;
			end else begin
				row = y_lo;
				if (col < x_hi) begin
					col++;
				end else begin
					step_done = 1'b1;
				end
			end
			if (step_done) begin
				if (major_pos >= major_end) begin
					p.last_cell = 1'b1;
					busy = 1'b0;
				end else begin
					err_acc -= minor_delta;
					if (err_acc < 0) begin
						minor_pos += dir ? 1 : -1;
						err_acc += major_delta;
					end
					major_pos++;
					place_brush();
				end
			end
			cells_due.push_back(p);
			return 1'b1;
		endfunction

		function void match_cell(pix_t got);
			pix_t e;
			if (cells_due.size() == 0) begin
				$error("pix_data transfer with no cell expected");
				faults++;
				return;
			end
			e = cells_due.pop_front();
			if (got.pixel_x !== e.pixel_x) begin
				$error("pixel_x expected %0d got %0d", e.pixel_x, got.pixel_x);
				faults++;
			end
			if (got.pixel_y !== e.pixel_y) begin
				$error("pixel_y expected %0d got %0d", e.pixel_y, got.pixel_y);
				faults++;
			end
			if (got.pixel_color !== e.pixel_color) begin
				$error("pixel_color expected %h got %h", e.pixel_color, got.pixel_color);
				faults++;
			end
			if (got.write_enable !== e.write_enable) begin
				$error("write_enable expected %b got %b", e.write_enable, got.write_enable);
				faults++;
			end
			if (got.last_cell !== e.last_cell) begin
				$error("last_cell expected %b got %b", e.last_cell, got.last_cell);
				faults++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [0:0] cfg_index = REG_SCREEN_WIDTH;
	logic [7:0] cfg_data = 8'd0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	item_t      item_data = '0;
	logic       pix_valid;
	logic       pix_stall = 1'b0;
	pix_t       pix_data;

	line_cell_checker board = new();
	bit               calm;

	thick_line_rasterizer_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_data  (item_data),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix_data   (pix_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("thick_line_rasterizer_unit: mismatch");
		$finish;
	end

	function automatic int pick_gap();
		return calm ? 0 : $urandom_range(0, 4);
	endfunction

	function automatic int pick_brush();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return 0;
		if (r < 40) return 1;
		if (r < 65) return 2;
		if (r < 85) return 3;
		if (r < 97) return $urandom_range(4, 16);
		return $urandom_range(17, 255);
	endfunction

	function automatic item_t make_start(int x0, int y0, int x1, int y1, int c, int b);
		item_t it;
		it.mode = MODE_START;
		it.start_x = x0[11:0];
		it.start_y = y0[11:0];
		it.end_x = x1[11:0];
		it.end_y = y1[11:0];
		it.line_color = c[15:0];
		it.brush_size = b[7:0];
		return it;
	endfunction

	// tick with random don't-care fields
	function automatic item_t make_tick();
		item_t it;
		it = make_start($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		it.mode = MODE_TICK;
		return it;
	endfunction

	function automatic item_t random_line(int w, int h);
		int x0;
		int y0;
		if ($urandom_range(0, 15) == 0) begin
			return make_start($urandom, $urandom, $urandom, $urandom, $urandom, pick_brush());
		end
		x0 = $urandom_range(0, w + 12) - 6;
		y0 = $urandom_range(0, h + 12) - 6;
		return make_start(x0, y0, x0 + $urandom_range(0, 16) - 8, y0 + $urandom_range(0, 16) - 8,
			$urandom, pick_brush());
	endfunction

	task automatic send(input item_t it, output bit counted);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item_data <= it;
		do @(posedge clk); while (item_stall);
		counted = board.take_item(it);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_reg(idx, val);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (board.waiting()) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic start_line(input int x0, input int y0, input int x1, input int y1,
			input int c, input int b, input int ticks);
		bit dummy;
		send(make_start(x0, y0, x1, y1, c, b), dummy);
		repeat (ticks) send(make_tick(), dummy);
	endtask

	// receiver side: random stall before each transfer
	initial begin
		int n;
		forever begin
			n = pick_gap();
			if (n > 0) begin
				pix_stall <= 1'b1;
				repeat (n) @(posedge clk);
				pix_stall <= 1'b0;
			end
			do @(posedge clk); while (pix_valid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pix_valid === 1'b1 && !pix_stall) board.match_cell(pix_data);
	end

	initial begin
		bit counted;
		int w;
		int h;
		int n;
		int k;
		int cap;
		int r;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(make_tick(), counted);
		start_line(0, 0, 0, 0, 16'hFFFF, 1, 2);
		start_line(-2048, -2048, 2047, 2047, 16'h0000, 255, 2);
		start_line(10, 10, 14, 11, 16'h1234, 0, 2);
		start_line(3, 9, 5, 2, 16'hA5A5, 2, 5);
		start_line(2047, -2048, -2048, 2047, 16'h5A5A, 1, 1);
		start_line(0, 127, 2, 125, 16'hF0F0, 3, 4);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin w = 255; h = 255; end
				1: begin w = 1; h = 1; end
				2: begin w = 0; h = $urandom_range(1, 255); end
				3: begin w = $urandom_range(1, 255); h = 0; end
				4: begin w = 128; h = 128; end
				default: begin w = $urandom_range(1, 64); h = $urandom_range(1, 255); end
			endcase
			write_reg(REG_SCREEN_WIDTH, w[7:0]);
			write_reg(REG_SCREEN_HEIGHT, h[7:0]);
			n = 0;
			while (n < 130) begin
				calm = ($urandom_range(0, 7) == 0);
				r = $urandom_range(0, 99);
				if (r < 8) begin
					send(make_tick(), counted);
					if (counted) n++;
				end else begin
					send(random_line(w, h), counted);
					n++;
					k = 0;
					cap = (r < 20) ? $urandom_range(0, 5) : 120;
					while (board.line_open() && k < cap) begin
						send(make_tick(), counted);
						k++;
						n++;
					end
				end
			end
			calm = 1'b0;
			drain();
		end

		if (board.faults == 0) begin
			$display("thick_line_rasterizer_unit: match");
		end else begin
			$display("thick_line_rasterizer_unit: mismatch");
		end
		$finish;
	end

endmodule
